FILE: src/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, constants and round tables for the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5_pkg;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  LEN_POS = 6'd56;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // start/done handshake between sequencer and compression core
    typedef struct packed {
        logic start;
    } t_cmp_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cmp_sts;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756; 6'd2: k = 32'h242070db;
            6'd3: k = 32'hc1bdceee; 6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501; 6'd8: k = 32'h698098d8;
            6'd9: k = 32'h8b44f7af; 6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
            6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
            6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
            6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
            6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
            6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
            6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
            6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
            6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
            default: k = 32'heb86d391;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [3:0] idx);
        logic [4:0] s;
        unique case (idx)
            4'd0: s = 5'd7;   4'd1: s = 5'd12;  4'd2: s = 5'd17;  4'd3: s = 5'd22;
            4'd4: s = 5'd5;   4'd5: s = 5'd9;   4'd6: s = 5'd14;  4'd7: s = 5'd20;
            4'd8: s = 5'd4;   4'd9: s = 5'd11;  4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
        endcase
        return s;
    endfunction

endpackage

FILE: src/md5_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 compression core
// Holds the block as 16 words and the chaining value; one round per cycle
// through a single shared round unit, 64 rounds per block.
// ----------------------------------------------------------------------------
module md5_core
    import md5_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [5:0]  i_wr_addr,
    input  logic [7:0]  i_wr_byte,
    input  t_cmp_ctl    i_ctl,
    input  logic        i_iv_load,
    output t_cmp_sts    o_sts,
    output logic [127:0] o_chain
);

    logic [31:0] r_w [16];
    logic [31:0] r_ch [4];
    logic [31:0] r_a, r_b, r_c, r_d;
    logic [5:0]  r_rnd;
    logic        r_busy, r_fin, r_done;

    logic [1:0]  phase;
    logic [31:0] f, sum, rot;
    logic [3:0]  g;
    logic [4:0]  sh;
    logic [5:0]  i5, i3, i7;

    assign phase = r_rnd[5:4];
    assign i5 = (r_rnd << 2) + r_rnd + 6'd1;
    assign i3 = (r_rnd << 1) + r_rnd + 6'd5;
    assign i7 = (r_rnd << 3) - r_rnd;

    always_comb begin
        unique case (phase)
            2'd0: begin f = (r_b & r_c) | (~r_b & r_d); g = r_rnd[3:0]; end
            2'd1: begin f = (r_b & r_d) | (r_c & ~r_d); g = i5[3:0]; end
            2'd2: begin f = r_b ^ r_c ^ r_d;            g = i3[3:0]; end
            default: begin f = r_c ^ (r_b | ~r_d);      g = i7[3:0]; end
        endcase
        sh  = md5_s({phase, r_rnd[1:0]});
        sum = r_a + f + md5_k(r_rnd) + r_w[g];
        rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            unique case (i_wr_addr[1:0])
                2'd0: r_w[i_wr_addr[5:2]][7:0]   <= i_wr_byte;
                2'd1: r_w[i_wr_addr[5:2]][15:8]  <= i_wr_byte;
                2'd2: r_w[i_wr_addr[5:2]][23:16] <= i_wr_byte;
                default: r_w[i_wr_addr[5:2]][31:24] <= i_wr_byte;
            endcase
        end
        if (i_ctl.start) begin
            r_a <= r_ch[0]; r_b <= r_ch[1]; r_c <= r_ch[2]; r_d <= r_ch[3];
        end else if (r_busy) begin
            r_a <= r_d; r_d <= r_c; r_c <= r_b; r_b <= r_b + rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_fin <= 1'b0; r_done <= 1'b0; r_rnd <= '0;
            r_ch[0] <= IV_A; r_ch[1] <= IV_B; r_ch[2] <= IV_C; r_ch[3] <= IV_D;
        end else begin
            r_done <= 1'b0;
            r_fin  <= 1'b0;
            if (i_iv_load) begin
                r_ch[0] <= IV_A; r_ch[1] <= IV_B; r_ch[2] <= IV_C; r_ch[3] <= IV_D;
            end
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_rnd  <= '0;
            end else if (r_busy) begin
                r_rnd <= r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
            // fold the working registers into the chain after the last round
            if (r_fin) begin
                r_ch[0] <= r_ch[0] + r_a; r_ch[1] <= r_ch[1] + r_b;
                r_ch[2] <= r_ch[2] + r_c; r_ch[3] <= r_ch[3] + r_d;
                r_done  <= 1'b1;
            end
        end
    end

    assign o_sts.busy = r_busy | r_fin;
    assign o_sts.done = r_done;
    assign o_chain = {r_ch[3], r_ch[2], r_ch[1], r_ch[0]};

endmodule

FILE: src/md5_stream_hasher_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 stream hasher
// Byte-serial MD5 (RFC 1321) with padding, length and four-word digest out.
// ----------------------------------------------------------------------------
//  channel | direction | payload    | handshake
//  in      | input     | t_in_item  | i_in_valid / o_in_ready
//  out     | output    | t_out_item | o_out_valid / i_out_ready
//
//  A byte item that does not close a block leaves the input ready; the 64th
//  byte of a block holds the input while the round unit runs its 64 rounds
//  (one per cycle) and folds the chain. An end item pads one byte a
//  cycle, runs one or two blocks, then offers four digest words; the input
//  stays blocked until the last word is taken. Output stalls hold the word.
//  Reset (synchronous, active low) restores the initial vector and counters.
module md5_stream_hasher_unit
    import md5_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_WAIT = 3'd1;
    localparam logic [2:0] ST_PAD  = 3'd2;
    localparam logic [2:0] ST_PWT  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  r_st, n_st;
    logic [5:0]  r_fill, n_fill;
    logic [63:0] r_bits, n_bits;
    logic [63:0] r_len, n_len;
    logic        r_pad80, n_pad80;
    logic        r_end, n_end;
    logic [1:0]  r_widx, n_widx;

    logic        wr_en, iv_load;
    logic [7:0]  wr_byte;
    t_cmp_ctl    ctl;
    t_cmp_sts    sts;
    logic [127:0] chain;
    logic        acc;

    md5_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_wr_en(wr_en), .i_wr_addr(r_fill),
        .i_wr_byte(wr_byte), .i_ctl(ctl), .i_iv_load(iv_load), .o_sts(sts),
        .o_chain(chain)
    );

    assign o_in_ready = (r_st == ST_IDLE);
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        logic [5:0] lsel;
        n_st = r_st; n_fill = r_fill; n_bits = r_bits; n_len = r_len;
        n_pad80 = r_pad80; n_end = r_end; n_widx = r_widx;
        wr_en = 1'b0; wr_byte = 8'h00; ctl.start = 1'b0; iv_load = 1'b0;
        lsel = r_fill - LEN_POS;
        unique case (r_st)
            ST_IDLE: begin
                if (acc) begin
                    n_end = i_in_data.end_of_message;
                    n_pad80 = 1'b1;
                    if (i_in_data.byte_present) begin
                        wr_en = 1'b1; wr_byte = i_in_data.data_byte;
                        n_bits = r_bits + 64'd8;
                        n_fill = r_fill + 6'd1;
                        if (r_fill == 6'd63) begin
                            ctl.start = 1'b1; n_st = ST_WAIT;
                        end else if (i_in_data.end_of_message) begin
                            n_st = ST_PAD; n_len = r_bits + 64'd8;
                        end
                    end else if (i_in_data.end_of_message) begin
                        n_st = ST_PAD; n_len = r_bits;
                    end
                end
            end
            ST_WAIT: begin
                if (sts.done) begin
                    n_st = r_end ? ST_PAD : ST_IDLE;
                    n_len = r_bits;
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (r_pad80) begin
                    wr_byte = PAD_BYTE; n_pad80 = 1'b0;
                    // from here on r_end marks the block that carries the length
                    n_end = (r_fill < LEN_POS);
                end else if (r_end && r_fill >= LEN_POS) begin
                    wr_byte = r_len[{lsel[2:0], 3'b000} +: 8];
                end
                n_fill = r_fill + 6'd1;
                if (r_fill == 6'd63) begin
                    ctl.start = 1'b1; n_st = ST_PWT;
                end
            end
            ST_PWT: begin
                if (sts.done) begin
                    n_widx = 2'd0;
                    if (r_end) begin
                        n_st = ST_OUT;
                    end else begin
                        // length did not fit behind the pad byte: one more block
                        n_st = ST_PAD; n_end = 1'b1;
                    end
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_widx = r_widx + 2'd1;
                    if (r_widx == 2'd3) begin
                        n_st = ST_IDLE; iv_load = 1'b1;
                        n_bits = '0; n_fill = '0;
                    end
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_fill <= '0; r_bits <= '0; r_pad80 <= 1'b0;
            r_end <= 1'b0; r_widx <= '0;
        end else begin
            r_st <= n_st; r_fill <= n_fill; r_bits <= n_bits; r_pad80 <= n_pad80;
            r_end <= n_end; r_widx <= n_widx;
        end
        r_len <= n_len;
    end

    assign o_out_valid = (r_st == ST_OUT);
    assign o_out_data.digest_word = chain[{r_widx, 5'b00000} +: 32];
    assign o_out_data.word_index = r_widx;
    assign o_out_data.last_word = (r_widx == 2'd3);

endmodule
